FILE: sv/ccdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccdc_pkg;

  // configuration register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_STAGE       = 3'd0;
  localparam reg_idx_t REG_ENABLES     = 3'd1;
  localparam reg_idx_t REG_REF_VALUE   = 3'd2;
  localparam reg_idx_t REG_ZERO_GAIN   = 3'd3;
  localparam reg_idx_t REG_ACTIVE_GAIN = 3'd4;
  localparam reg_idx_t REG_DESMEAR_EN  = 3'd5;
  localparam reg_idx_t REG_SMEAR_SCALE = 3'd6;
  localparam reg_idx_t REG_IOF_GAIN    = 3'd7;

  localparam logic [1:0]  STAGE_DARK     = 2'd0;
  localparam logic [1:0]  STAGE_FLAT     = 2'd1;
  localparam logic [1:0]  STAGE_IOF      = 2'd2;
  localparam logic [16:0] SCALE_ONE      = 17'd65536;
  localparam logic [31:0] IOF_GAIN_ONE   = 32'd16777216;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] raw_pixel;
    logic               raw_valid;
    logic signed [31:0] ref_pixel;
    logic signed [31:0] zero_pixel;
    logic signed [31:0] active_pixel;
    logic [17:0]        flat_pixel;
    logic [9:0]         column;
    logic               first_line;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] corrected_pixel;
    logic               is_null;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         stage;
    logic [2:0]         enables;
    logic signed [31:0] reference_value;
    logic signed [31:0] zero_gain;
    logic signed [31:0] active_gain;
    logic               desmear_en;
    logic [16:0]        smear_scale;
    logic [31:0]        iof_gain;
  } cfg_t;

  // pixel word passed between pipeline sections
  typedef struct packed {
    logic signed [31:0] value;
    logic               is_null;
    logic [17:0]        flat;
    logic               first_line;
  } pix_t;

  // shift right by n, round half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                 input int unsigned n);
    logic        neg;
    logic [63:0] m;
    neg = x[63];
    m = neg ? (64'd0 - x) : x;
    m = (m + (64'd1 << (n - 1))) >> n;
    return neg ? $signed(64'd0 - m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ccdc_dark.sv
`timescale 1ns / 1ps
`default_nettype none
module ccdc_dark #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ccdc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_rdy,
  input  wire ccdc_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_rdy,
  output ccdc_pkg::pix_t                     out_data,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_idx
);
  localparam int AW = $clog2(MAX_WIDTH);
  // column modulo the line store: reciprocal multiply, exact for 10-bit columns
  localparam int unsigned RECIP_I = (32'd1 << 24) / MAX_WIDTH + 1;
  localparam logic [24:0] RECIP = RECIP_I[24:0];

  // stage D0: input word
  logic                  d0_v_r;
  ccdc_pkg::in_word_t    d0_r;
  // stage D1: products
  logic                  d1_v_r;
  logic signed [63:0]    zprod_r, aprod_r;
  logic signed [32:0]    refsum1_r;
  logic signed [31:0]    raw1_r;
  logic                  null1_r, first1_r;
  logic [17:0]           flat1_r;
  logic [9:0]            col1_r;
  logic [34:0]           colr_r;
  // stage D2: rounded terms
  logic                  d2_v_r;
  logic signed [39:0]    zt_r, at_r;
  logic signed [32:0]    refsum2_r;
  logic signed [31:0]    raw2_r;
  logic                  null2_r, first2_r;
  logic [17:0]           flat2_r;
  logic [9:0]            col2_r;
  logic [22:0]           qw_r;
  // stage D3: output
  logic                  d3_v_r;
  ccdc_pkg::pix_t        d3_r;
  logic [AW-1:0]         idx_r;

  logic en0, en1, en2, en3;
  logic signed [63:0] zprod_nxt, aprod_nxt, zt_full, at_full, diff;
  logic signed [32:0] refsum_nxt;
  logic [34:0]        colr_nxt;
  logic [22:0]        qw_nxt;
  logic signed [41:0] sum;
  logic [9:0]         idx_full;
  ccdc_pkg::pix_t     pix_nxt;
  logic [AW-1:0]      idx_nxt;

  // advance a stage when it is empty or the next one advances
  assign en3 = !d3_v_r || out_rdy;
  assign en2 = !d2_v_r || en3;
  assign en1 = !d1_v_r || en2;
  assign en0 = !d0_v_r || en1;
  assign in_rdy = en0;

  assign zprod_nxt  = 64'(d0_r.zero_pixel) * 64'(cfg.zero_gain);
  assign aprod_nxt  = 64'(d0_r.active_pixel) * 64'(cfg.active_gain);
  assign refsum_nxt = 33'(cfg.reference_value) + 33'(d0_r.ref_pixel);
  assign colr_nxt   = 35'(d0_r.column) * 35'(RECIP);

  assign zt_full = ccdc_pkg::rnd_shr(zprod_r, 24);
  assign at_full = ccdc_pkg::rnd_shr(aprod_r, 24);
  assign qw_nxt  = 23'(colr_r[33:24]) * 23'(MAX_WIDTH);

  always_comb begin
    sum = '0;
    if (cfg.enables[0]) sum = sum + 42'(refsum2_r);
    if (cfg.enables[1]) sum = sum + 42'(zt_r);
    if (cfg.enables[2]) sum = sum + 42'(at_r);
    diff = 64'(raw2_r) - 64'(sum);
    idx_full = col2_r - qw_r[9:0];
    idx_nxt = AW'(idx_full);
    pix_nxt.value      = ccdc_pkg::sat32(diff);
    pix_nxt.is_null    = null2_r;
    pix_nxt.flat       = flat2_r;
    pix_nxt.first_line = first2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_v_r <= 1'b0;
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
    end else begin
      if (en0) d0_v_r <= in_valid;
      if (en1) d1_v_r <= d0_v_r;
      if (en2) d2_v_r <= d1_v_r;
      if (en3) d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) d0_r <= in_data;
    if (en1) begin
      zprod_r   <= zprod_nxt;
      aprod_r   <= aprod_nxt;
      refsum1_r <= refsum_nxt;
      raw1_r    <= d0_r.raw_pixel;
      null1_r   <= !d0_r.raw_valid;
      first1_r  <= d0_r.first_line;
      flat1_r   <= d0_r.flat_pixel;
      col1_r    <= d0_r.column;
      colr_r    <= colr_nxt;
    end
    if (en2) begin
      zt_r      <= zt_full[39:0];
      at_r      <= at_full[39:0];
      refsum2_r <= refsum1_r;
      raw2_r    <= raw1_r;
      null2_r   <= null1_r;
      first2_r  <= first1_r;
      flat2_r   <= flat1_r;
      col2_r    <= col1_r;
      qw_r      <= qw_nxt;
    end
    if (en3) begin
      d3_r  <= pix_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign out_valid = d3_v_r;
  assign out_data  = d3_r;
  assign out_idx   = idx_r;
endmodule
`default_nettype wire

FILE: sv/ccdc_smear.sv
`timescale 1ns / 1ps
`default_nettype none
module ccdc_smear #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ccdc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_rdy,
  input  wire ccdc_pkg::pix_t                in_data,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  in_idx,
  output logic                               out_valid,
  input  wire logic                          out_rdy,
  output ccdc_pkg::pix_t                     out_data,
  output logic                               busy
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WIDTH - 1);

  logic signed [31:0] mem [MAX_WIDTH];

  logic               clr_busy_r;
  logic [AW-1:0]      clr_cnt_r;

  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  ccdc_pkg::pix_t     s1_r, s2_r, s3_r, s4_r;
  logic [AW-1:0]      s1_idx_r, s2_idx_r;
  logic signed [31:0] rd_r;
  logic signed [49:0] p1_r, p2_r;
  logic signed [31:0] sm_r;
  logic               apply_r;

  logic en1, en2, en3, en4, hazard, take, active, wr_en, apply_nxt;
  logic [16:0]        scl, inv;
  logic signed [49:0] p1_nxt, p2_nxt;
  logic signed [63:0] sm_full, seed_full, diff;
  logic signed [31:0] sm_nxt, wdata;
  ccdc_pkg::pix_t     pix_nxt;

  assign active = (cfg.stage != ccdc_pkg::STAGE_DARK) && cfg.desmear_en;
  assign scl = (cfg.smear_scale > ccdc_pkg::SCALE_ONE) ? ccdc_pkg::SCALE_ONE
                                                       : cfg.smear_scale;
  assign inv = ccdc_pkg::SCALE_ONE - scl;

  assign en4 = !s4_v_r || out_rdy;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  // hold a word whose column is still being updated further down
  assign hazard = active && ((s1_v_r && (s1_idx_r == in_idx)) ||
                             (s2_v_r && (s2_idx_r == in_idx)));
  assign in_rdy = en1 && !hazard && !clr_busy_r;
  assign take   = in_valid && in_rdy;
  assign busy   = clr_busy_r;

  assign p1_nxt = 50'(s1_r.value) * 50'($signed({1'b0, scl}));
  assign p2_nxt = 50'(rd_r) * 50'($signed({1'b0, inv}));

  assign sm_full   = ccdc_pkg::rnd_shr(64'(p1_r) + 64'(p2_r), 16);
  assign seed_full = ccdc_pkg::rnd_shr(64'(p1_r), 16);
  assign sm_nxt    = ccdc_pkg::sat32(sm_full);

  always_comb begin
    wr_en = s2_v_r && en3 && active && (s2_r.first_line || !s2_r.is_null);
    if (s2_r.first_line) begin
      wdata = s2_r.is_null ? '0 : ccdc_pkg::sat32(seed_full);
    end else begin
      wdata = sm_nxt;
    end
    apply_nxt = active && !s2_r.first_line && !s2_r.is_null;
  end

  always_comb begin
    pix_nxt = s3_r;
    diff = 64'(s3_r.value) - 64'(sm_r);
    if (apply_r) begin
      pix_nxt.value   = ccdc_pkg::sat32(diff);
      pix_nxt.is_null = (diff <= 64'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) clr_busy_r <= 1'b0;
      end
      if (en1) s1_v_r <= take;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // line store: clear sweep after reset, then one write and one read a cycle
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[s2_idx_r] <= wdata;
    end
    if (take) rd_r <= mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (en1 && take) begin
      s1_r     <= in_data;
      s1_idx_r <= in_idx;
    end
    if (en2) begin
      s2_r     <= s1_r;
      s2_idx_r <= s1_idx_r;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
    end
    if (en3) begin
      s3_r    <= s2_r;
      sm_r    <= sm_nxt;
      apply_r <= apply_nxt;
    end
    if (en4) s4_r <= pix_nxt;
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_r;
endmodule
`default_nettype wire

FILE: sv/ccdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ccdc_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ccdc_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_rdy,
  input  wire ccdc_pkg::pix_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_rdy,
  output ccdc_pkg::pix_t       out_data
);
  // quotient bits 32..0, one per stage; larger quotients are caught up front
  localparam int QB = 33;

  logic               v0_v_r;
  ccdc_pkg::pix_t     v0_r;

  logic               sv_r   [0:QB];
  logic [47:0]        rem_r  [0:QB];
  logic [QB-1:0]      q_r    [0:QB];
  logic [17:0]        flat_r [0:QB];
  logic               neg_r  [0:QB];
  logic               ovf_r  [0:QB];
  logic               skip_r [0:QB];
  logic               nul_r  [0:QB];
  logic signed [31:0] val_r  [0:QB];
  logic               adv    [0:QB];

  logic               o_v_r;
  ccdc_pkg::pix_t     o_r;

  logic               adv_in, adv_out, neg0, nul0, skip0, ovf0;
  logic [31:0]        mag0;
  logic [47:0]        m2;
  logic [QB-1:0]      qf;
  ccdc_pkg::pix_t     pix_nxt;

  assign adv_out = !o_v_r || out_rdy;
  assign adv[QB] = !sv_r[QB] || adv_out;
  assign adv_in  = !v0_v_r || adv[0];
  assign in_rdy  = adv_in;

  always_comb begin
    neg0  = v0_r.value < 0;
    mag0  = neg0 ? 32'(-v0_r.value) : 32'(v0_r.value);
    m2    = {mag0, 16'd0} + 48'(v0_r.flat >> 1);
    nul0  = v0_r.is_null ||
            ((cfg.stage != ccdc_pkg::STAGE_DARK) && (v0_r.flat == '0));
    skip0 = (cfg.stage == ccdc_pkg::STAGE_DARK) || nul0;
    ovf0  = 51'(m2) >= {v0_r.flat, 33'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_v_r <= 1'b0;
      sv_r[0] <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_in) v0_v_r <= in_valid;
      if (adv[0]) sv_r[0] <= v0_v_r;
      if (adv_out) o_v_r <= sv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) v0_r <= in_data;
    if (adv[0]) begin
      rem_r[0]  <= m2;
      q_r[0]    <= '0;
      flat_r[0] <= v0_r.flat;
      neg_r[0]  <= neg0;
      ovf_r[0]  <= ovf0;
      skip_r[0] <= skip0;
      nul_r[0]  <= nul0;
      val_r[0]  <= v0_r.value;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= QB; j++) begin : g_step
      localparam int K = QB - j;
      logic [49:0] fk;
      logic        ge;
      assign fk = 50'(flat_r[j-1]) << K;
      assign ge = 50'(rem_r[j-1]) >= fk;
      if (j < QB) begin : g_adv
        assign adv[j] = !sv_r[j] || adv[j+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[j] <= 1'b0;
        end else if (adv[j]) begin
          sv_r[j] <= sv_r[j-1];
        end
      end

      // subtract the shifted divisor where it fits, set this quotient bit
      always_ff @(posedge clk) begin
        if (adv[j]) begin
          rem_r[j]  <= ge ? (rem_r[j-1] - fk[47:0]) : rem_r[j-1];
          q_r[j]    <= q_r[j-1] | (ge ? (QB'(1) << K) : '0);
          flat_r[j] <= flat_r[j-1];
          neg_r[j]  <= neg_r[j-1];
          ovf_r[j]  <= ovf_r[j-1];
          skip_r[j] <= skip_r[j-1];
          nul_r[j]  <= nul_r[j-1];
          val_r[j]  <= val_r[j-1];
        end
      end
    end
    assign adv[0] = !sv_r[0] || adv[1];
  endgenerate

  always_comb begin
    qf = q_r[QB];
    pix_nxt.flat       = flat_r[QB];
    pix_nxt.first_line = 1'b0;
    pix_nxt.is_null    = nul_r[QB];
    if (skip_r[QB]) begin
      pix_nxt.value = val_r[QB];
    end else if (neg_r[QB]) begin
      if (ovf_r[QB] || (qf > 33'h080000000)) begin
        pix_nxt.value = ccdc_pkg::S32_MIN[31:0];
      end else begin
        pix_nxt.value = $signed(32'd0 - qf[31:0]);
      end
    end else begin
      if (ovf_r[QB] || (qf > 33'h07FFFFFFF)) begin
        pix_nxt.value = ccdc_pkg::S32_MAX[31:0];
      end else begin
        pix_nxt.value = $signed(qf[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) o_r <= pix_nxt;
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;
endmodule
`default_nettype wire

FILE: sv/ccdc_iof.sv
`timescale 1ns / 1ps
`default_nettype none
module ccdc_iof (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ccdc_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_rdy,
  input  wire ccdc_pkg::pix_t      in_data,
  output logic                     out_valid,
  input  wire logic                out_rdy,
  output ccdc_pkg::out_word_t      out_data
);
  logic               i0_v_r, i1_v_r, i2_v_r;
  ccdc_pkg::pix_t     i0_r;
  logic [63:0]        prod_r;
  logic               neg_r, apply_r, nul_r;
  logic signed [31:0] val_r;
  ccdc_pkg::out_word_t i2_r;

  logic en0, en1, en2, neg0;
  logic [31:0] mag0;
  logic [63:0] prod_nxt, m;
  ccdc_pkg::out_word_t word_nxt;

  assign en2 = !i2_v_r || out_rdy;
  assign en1 = !i1_v_r || en2;
  assign en0 = !i0_v_r || en1;
  assign in_rdy = en0;

  assign neg0     = i0_r.value < 0;
  assign mag0     = neg0 ? 32'(-i0_r.value) : 32'(i0_r.value);
  assign prod_nxt = 64'(mag0) * 64'(cfg.iof_gain);

  always_comb begin
    m = (prod_r + 64'h800000) >> 24;
    word_nxt.is_null = nul_r;
    if (nul_r) begin
      word_nxt.corrected_pixel = '0;
    end else if (!apply_r) begin
      word_nxt.corrected_pixel = val_r;
    end else if (neg_r) begin
      word_nxt.corrected_pixel = (m > 64'h80000000) ? ccdc_pkg::S32_MIN[31:0]
                                                    : $signed(32'd0 - m[31:0]);
    end else begin
      word_nxt.corrected_pixel = (m > 64'h7FFFFFFF) ? ccdc_pkg::S32_MAX[31:0]
                                                    : $signed(m[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i0_v_r <= 1'b0;
      i1_v_r <= 1'b0;
      i2_v_r <= 1'b0;
    end else begin
      if (en0) i0_v_r <= in_valid;
      if (en1) i1_v_r <= i0_v_r;
      if (en2) i2_v_r <= i1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) i0_r <= in_data;
    if (en1) begin
      prod_r  <= prod_nxt;
      neg_r   <= neg0;
      apply_r <= cfg.stage[1];
      nul_r   <= i0_r.is_null;
      val_r   <= i0_r.value;
    end
    if (en2) i2_r <= word_nxt;
  end

  assign out_valid = i2_v_r;
  assign out_data  = i2_r;
endmodule
`default_nettype wire

FILE: sv/ccd_dark_desmear_flat_calibration_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Ports                            Word
// input    in_valid, in_stall, in_data      ccdc_pkg::in_word_t, one pixel and its refs
// result   out_valid, out_stall, out_data   ccdc_pkg::out_word_t, calibrated pixel
// config   cfg_wr_en, cfg_index, cfg_wdata  register write, no read-back
//
// One word enters per cycle while in_stall is low.
// The flat division sets the depth: one quotient bit per stage over 33 stages.
// A word is held off when its column is still in the smear update of a
// word just ahead. After reset the smear line store is swept to zero
// while in_stall stays high.
// Each stage holds its word when the one after it is full and stalled, so
// stalls lose and repeat nothing and bubbles close up.
module ccd_dark_desmear_flat_calibration_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ccdc_pkg::in_word_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ccdc_pkg::out_word_t        out_data,
  input  wire logic                  cfg_wr_en,
  input  wire ccdc_pkg::reg_idx_t    cfg_index,
  input  wire logic [31:0]           cfg_wdata
);
  localparam int AW = $clog2(MAX_WIDTH);

  ccdc_pkg::cfg_t cfg_r;

  logic               dark_rdy, dark_v, smear_rdy, smear_v, div_rdy, div_v, iof_rdy;
  logic               clr_busy;
  ccdc_pkg::pix_t     dark_word, smear_word, div_word;
  logic [AW-1:0]      dark_idx;

  // Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stage           <= ccdc_pkg::STAGE_IOF;
      cfg_r.enables         <= 3'b111;
      cfg_r.reference_value <= '0;
      cfg_r.zero_gain       <= '0;
      cfg_r.active_gain     <= '0;
      cfg_r.desmear_en      <= 1'b0;
      cfg_r.smear_scale     <= '0;
      cfg_r.iof_gain        <= ccdc_pkg::IOF_GAIN_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ccdc_pkg::REG_STAGE:       cfg_r.stage           <= cfg_wdata[1:0];
        ccdc_pkg::REG_ENABLES:     cfg_r.enables         <= cfg_wdata[2:0];
        ccdc_pkg::REG_REF_VALUE:   cfg_r.reference_value <= $signed(cfg_wdata);
        ccdc_pkg::REG_ZERO_GAIN:   cfg_r.zero_gain       <= $signed(cfg_wdata);
        ccdc_pkg::REG_ACTIVE_GAIN: cfg_r.active_gain     <= $signed(cfg_wdata);
        ccdc_pkg::REG_DESMEAR_EN:  cfg_r.desmear_en      <= cfg_wdata[0];
        ccdc_pkg::REG_SMEAR_SCALE: cfg_r.smear_scale     <= cfg_wdata[16:0];
        ccdc_pkg::REG_IOF_GAIN:    cfg_r.iof_gain        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold input during the store sweep or when the front section is full.
  assign in_stall = !dark_rdy || clr_busy;

  // Dark subtraction: products, rounding, enabled sum and saturation.
  ccdc_dark #(.MAX_WIDTH(MAX_WIDTH)) u_dark (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid && !clr_busy),
    .in_rdy    (dark_rdy),
    .in_data   (in_data),
    .out_valid (dark_v),
    .out_rdy   (smear_rdy),
    .out_data  (dark_word),
    .out_idx   (dark_idx)
  );

  // Smear recurrence over the per-column line store.
  ccdc_smear #(.MAX_WIDTH(MAX_WIDTH)) u_smear (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (dark_v),
    .in_rdy    (smear_rdy),
    .in_data   (dark_word),
    .in_idx    (dark_idx),
    .out_valid (smear_v),
    .out_rdy   (div_rdy),
    .out_data  (smear_word),
    .busy      (clr_busy)
  );

  // Flat-field division, rounded and saturated; passed through in the dark stage.
  ccdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (smear_v),
    .in_rdy    (div_rdy),
    .in_data   (smear_word),
    .out_valid (div_v),
    .out_rdy   (iof_rdy),
    .out_data  (div_word)
  );

  // I/F gain and the final result register.
  ccdc_iof u_iof (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (div_v),
    .in_rdy    (iof_rdy),
    .in_data   (div_word),
    .out_valid (out_valid),
    .out_rdy   (!out_stall),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire
